// ===== rtl/core/rpn_stack_calculator_defines.svh =====
// assertion macros used by the rpn calculator rtl
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// condition that must hold on every clock out of reset
`define RPN_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define RPN_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rpn_pkg.sv =====
package rpn_pkg;

	localparam int QW        = 32;
	localparam int FRAC      = 16;
	localparam int MAG_W     = QW + FRAC;
	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 48;
	localparam int STEP_W    = 6;
	localparam int DEPTH_W   = 8;

	localparam logic [QW-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		FN_PUSH = 3'd0,
		FN_ADD  = 3'd1,
		FN_SUB  = 3'd2,
		FN_MUL  = 3'd3,
		FN_DIV  = 3'd4,
		FN_POP  = 3'd5,
		FN_UNK  = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} alu_rsp_t;

endpackage

// ===== rtl/core/rpn_stack_calculator.sv =====
// channel   direction  handshake               payload
// token     in         tok_valid / tok_stall   func, number
// result    out        res_valid / res_stall   top_value, depth, underflow, overflow,
//                                              zero_divisor, unknown_command, saturated
//
// one token at a time; tok_stall stays high from a transfer until its result is registered.
// push and unknown go straight to output; pop and zero divisor pass through a read state;
// arithmetic waits on the alu; mul/div go one bit per cycle through its shared 33-bit adder.
// a result that waits under res_stall holds the next token's result back in its last state.
// reset empties the stack at once; stack memory contents are never cleared.
`include "rpn_stack_calculator_defines.svh"

module rpn_stack_calculator import rpn_pkg::*; #(
	parameter int unsigned STACK_DEPTH = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tok_valid,
	output logic                 tok_stall,
	input  logic [2:0]           func,
	input  logic signed [QW-1:0] number,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic signed [QW-1:0] top_value,
	output logic [DEPTH_W-1:0]   depth,
	output logic                 underflow,
	output logic                 overflow,
	output logic                 zero_divisor,
	output logic                 unknown_command,
	output logic                 saturated
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_OUT
	} st_t;

	st_t                 state_q;
	func_t               fn_q;
	logic [CW-1:0]       count_q;
	logic [QW-1:0]       top_q;
	logic [QW-1:0]       pop_q;
	logic                under_q;
	logic                over_q;
	logic                zdiv_q;
	logic                unk_q;
	logic                sat_q;

	logic                res_valid_q;
	logic [QW-1:0]       top_value_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                underflow_q;
	logic                overflow_q;
	logic                zero_divisor_q;
	logic                unknown_command_q;
	logic                saturated_q;

	logic [QW-1:0]       stack_mem [STACK_DEPTH];
	logic [QW-1:0]       rdata_q;
	logic [AW-1:0]       raddr;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [QW-1:0]       mem_wdata;

	logic                tok_xfer;
	logic                has_room;
	logic                div_by_zero;
	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;
	alu_op_t             alu_op;
	logic [QW-1:0]       alu_opa;
	logic [QW-1:0]       alu_result;

	assign tok_stall   = (state_q != ST_IDLE);
	assign tok_xfer    = tok_valid && !tok_stall;
	assign has_room    = (count_q < CW'(STACK_DEPTH));
	assign div_by_zero = (fn_q == FN_DIV) && (pop_q == '0);

	// entry just below the top, for the second pop
	assign raddr = (count_q >= CW'(2)) ? AW'(count_q - CW'(2)) : '0;

	assign mem_we    = (tok_xfer && func_t'(func) == FN_PUSH && has_room) ||
	                   (state_q == ST_WAIT && alu_rsp.done);
	assign mem_waddr = AW'(count_q);
	assign mem_wdata = (state_q == ST_WAIT) ? alu_result : number;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= stack_mem[raddr];
	end

	always_comb begin
		case (fn_q)
			FN_SUB:  alu_op = ALU_SUB;
			FN_MUL:  alu_op = ALU_MUL;
			FN_DIV:  alu_op = ALU_DIV;
			default: alu_op = ALU_ADD;
		endcase
	end

	assign alu_opa = (count_q != '0) ? rdata_q : '0;
	assign alu_req = '{
		start: (state_q == ST_READ) && (fn_q != FN_POP) && !div_by_zero,
		op:    alu_op
	};

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (alu_opa),
		.opb    (pop_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			fn_q              <= FN_PUSH;
			count_q           <= '0;
			top_q             <= '0;
			pop_q             <= '0;
			under_q           <= 1'b0;
			over_q            <= 1'b0;
			zdiv_q            <= 1'b0;
			unk_q             <= 1'b0;
			sat_q             <= 1'b0;
			res_valid_q       <= 1'b0;
			top_value_q       <= '0;
			depth_q           <= '0;
			underflow_q       <= 1'b0;
			overflow_q        <= 1'b0;
			zero_divisor_q    <= 1'b0;
			unknown_command_q <= 1'b0;
			saturated_q       <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != ST_OUT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tok_xfer) begin
						fn_q   <= func_t'(func);
						zdiv_q <= 1'b0;
						sat_q  <= 1'b0;
						case (func_t'(func))
							FN_PUSH: begin
								under_q <= 1'b0;
								unk_q   <= 1'b0;
								over_q  <= !has_room;
								if (has_room) begin
									top_q   <= number;
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_OUT;
							end
							FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_POP: begin
								over_q  <= 1'b0;
								unk_q   <= 1'b0;
								// right operand comes from the cached top
								pop_q   <= (count_q != '0) ? top_q : '0;
								under_q <= (count_q == '0);
								if (count_q != '0) begin
									count_q <= count_q - CW'(1);
								end
								state_q <= ST_READ;
							end
							default: begin
								under_q <= 1'b0;
								over_q  <= 1'b0;
								unk_q   <= 1'b1;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_READ: begin
					if (fn_q == FN_POP || div_by_zero) begin
						// entry below becomes the new top
						top_q   <= rdata_q;
						zdiv_q  <= div_by_zero;
						state_q <= ST_OUT;
					end else begin
						if (count_q == '0) begin
							under_q <= 1'b1;
						end else begin
							count_q <= count_q - CW'(1);
						end
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (alu_rsp.done) begin
						top_q   <= alu_result;
						count_q <= count_q + CW'(1);
						sat_q   <= alu_rsp.sat;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						if (fn_q == FN_POP) begin
							top_value_q <= pop_q;
						end else begin
							top_value_q <= (count_q != '0) ? top_q : '0;
						end
						depth_q           <= DEPTH_W'(count_q);
						underflow_q       <= under_q;
						overflow_q        <= over_q;
						zero_divisor_q    <= zdiv_q;
						unknown_command_q <= unk_q;
						saturated_q       <= sat_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid       = res_valid_q;
	assign top_value       = top_value_q;
	assign depth           = depth_q;
	assign underflow       = underflow_q;
	assign overflow        = overflow_q;
	assign zero_divisor    = zero_divisor_q;
	assign unknown_command = unknown_command_q;
	assign saturated       = saturated_q;

	`RPN_ASSERT_HOLDS(a_count_range, count_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`RPN_ASSERT_IMPL(a_done_in_wait, alu_rsp.done, state_q == ST_WAIT, "alu done outside wait")
	`RPN_ASSERT_IMPL(a_room_for_result, state_q == ST_WAIT, has_room, "no room to push result")

endmodule

// ===== rtl/core/rpn_alu.sv =====
module rpn_alu import rpn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  alu_req_t      req,
	input  logic [QW-1:0] opa,
	input  logic [QW-1:0] opb,
	output alu_rsp_t      rsp,
	output logic [QW-1:0] result
);

	typedef enum logic [2:0] {
		AL_IDLE,
		AL_SUM,
		AL_ABSA,
		AL_ABSB,
		AL_MUL,
		AL_DIV,
		AL_FIN
	} al_state_t;

	al_state_t          st_q;
	alu_op_t            op_q;
	logic [QW-1:0]      opa_q;
	logic [QW-1:0]      opb_q;
	logic [QW-1:0]      acc_q;
	logic [MAG_W-1:0]   sh_q;
	logic [STEP_W-1:0]  step_q;
	logic               neg_q;
	logic [QW-1:0]      res_q;
	logic               sat_q;
	logic               done_q;

	// the one shared adder
	logic [QW:0]        add_x;
	logic [QW:0]        add_y;
	logic               add_sub;
	logic [QW:0]        add_sum;

	logic [MAG_W-1:0]   mag;
	logic [QW-1:0]      abs_b;
	logic [QW:0]        mul_s;
	logic               big_neg;
	logic               big_pos;

	assign add_sum = add_x + (add_y ^ {(QW+1){add_sub}}) + (QW+1)'(add_sub);

	// product is taken >> FRAC, quotient is already scaled
	assign mag     = (op_q == ALU_MUL) ? {acc_q, sh_q[QW-1:FRAC]} : sh_q;
	assign abs_b   = opb_q[QW-1] ? add_sum[QW-1:0] : opb_q;
	assign mul_s   = sh_q[0] ? add_sum : {1'b0, acc_q};
	assign big_neg = (|mag[MAG_W-1:QW]) | (mag[QW-1] & (|mag[QW-2:0]));
	assign big_pos = |mag[MAG_W-1:QW-1];

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (st_q)
			AL_SUM: begin
				add_x   = {opa_q[QW-1], opa_q};
				add_y   = {opb_q[QW-1], opb_q};
				add_sub = (op_q == ALU_SUB);
			end
			AL_ABSA: begin
				add_y   = {opa_q[QW-1], opa_q};
				add_sub = 1'b1;
			end
			AL_ABSB: begin
				add_y   = {opb_q[QW-1], opb_q};
				add_sub = 1'b1;
			end
			AL_MUL: begin
				add_x = {1'b0, acc_q};
				add_y = {1'b0, opa_q};
			end
			AL_DIV: begin
				// trial subtract of the divisor from the shifted remainder
				add_x   = {acc_q, sh_q[MAG_W-1]};
				add_y   = {1'b0, opb_q};
				add_sub = 1'b1;
			end
			AL_FIN: begin
				add_y   = {1'b0, mag[QW-1:0]};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= AL_IDLE;
			op_q   <= ALU_ADD;
			opa_q  <= '0;
			opb_q  <= '0;
			acc_q  <= '0;
			sh_q   <= '0;
			step_q <= '0;
			neg_q  <= 1'b0;
			res_q  <= '0;
			sat_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == AL_SUM) || (st_q == AL_FIN);
			case (st_q)
				AL_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						opa_q <= opa;
						opb_q <= opb;
						neg_q <= opa[QW-1] ^ opb[QW-1];
						if (req.op == ALU_ADD || req.op == ALU_SUB) begin
							st_q <= AL_SUM;
						end else begin
							st_q <= AL_ABSA;
						end
					end
				end
				AL_SUM: begin
					if (add_sum[QW] != add_sum[QW-1]) begin
						sat_q <= 1'b1;
						res_q <= add_sum[QW] ? Q_MIN : Q_MAX;
					end else begin
						sat_q <= 1'b0;
						res_q <= add_sum[QW-1:0];
					end
					st_q <= AL_IDLE;
				end
				AL_ABSA: begin
					if (opa_q[QW-1]) begin
						opa_q <= add_sum[QW-1:0];
					end
					st_q <= AL_ABSB;
				end
				AL_ABSB: begin
					acc_q <= '0;
					opb_q <= abs_b;
					if (op_q == ALU_MUL) begin
						sh_q   <= {{(MAG_W-QW){1'b0}}, abs_b};
						step_q <= STEP_W'(MUL_STEPS);
						st_q   <= AL_MUL;
					end else begin
						sh_q   <= {opa_q, {FRAC{1'b0}}};
						step_q <= STEP_W'(DIV_STEPS);
						st_q   <= AL_DIV;
					end
				end
				AL_MUL: begin
					acc_q          <= mul_s[QW:1];
					sh_q[QW-1:0]   <= {mul_s[0], sh_q[QW-1:1]};
					step_q         <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						st_q <= AL_FIN;
					end
				end
				AL_DIV: begin
					if (!add_sum[QW]) begin
						acc_q <= add_sum[QW-1:0];
					end else begin
						acc_q <= {acc_q[QW-2:0], sh_q[MAG_W-1]};
					end
					sh_q   <= {sh_q[MAG_W-2:0], ~add_sum[QW]};
					step_q <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						st_q <= AL_FIN;
					end
				end
				AL_FIN: begin
					if (neg_q) begin
						sat_q <= big_neg;
						res_q <= big_neg ? Q_MIN : add_sum[QW-1:0];
					end else begin
						sat_q <= big_pos;
						res_q <= big_pos ? Q_MAX : mag[QW-1:0];
					end
					st_q <= AL_IDLE;
				end
				default: begin
					st_q <= AL_IDLE;
				end
			endcase
		end
	end

	assign rsp    = '{done: done_q, sat: sat_q};
	assign result = res_q;

endmodule
